[sv/psc_pkg.sv]
// Shared constants, control types and helper functions of the pre-emphasis shaping chain.
`default_nettype none
package psc_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int INT_W       = 24;
  localparam int COEFF_W     = 16;
  localparam int GAIN_W      = 16;
  localparam int COEFF_FRAC  = 14;
  localparam int GAIN_FRAC   = 8;
  localparam int SUM_W       = INT_W + 2;
  localparam int MUL_B_W     = GAIN_W + 1;
  localparam int PROD_W      = SUM_W + MUL_B_W;
  localparam int ACC_W       = INT_W + 6;
  localparam int SAMPLE_MAX  = 2 ** (SAMPLE_W - 1) - 1;
  localparam int WARM_W      = 4;
  localparam int WARM_SINGLE = 4;
  localparam int WARM_TWICE  = 8;
  localparam int LOW_B_START = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int OP_W        = 3;

  // Operations of the shared multiplier.
  localparam logic [OP_W-1:0] OP_PRE_A = 3'd0;
  localparam logic [OP_W-1:0] OP_PRE_B = 3'd1;
  localparam logic [OP_W-1:0] OP_LOW_A = 3'd2;
  localparam logic [OP_W-1:0] OP_LOW_B = 3'd3;
  localparam logic [OP_W-1:0] OP_GAIN  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LF    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TWICE = 2'd3;

  typedef struct packed {
    logic            busy;
    logic [OP_W-1:0] op;
    logic            mul_en;
    logic            acc_en;
    logic            out_load;
  } psc_ctrl_t;

  // Clamp a wide stage result to the signed internal width.
  function automatic logic signed [INT_W-1:0] sat_int(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(2 ** (INT_W - 1) - 1);
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      return hi[INT_W-1:0];
    end else if (v < lo) begin
      return lo[INT_W-1:0];
    end
    return v[INT_W-1:0];
  endfunction

endpackage
`default_nettype wire

[sv/psc_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none
module psc_mul (
  input  wire                                       clk_i,
  input  wire                                       en_i,
  input  wire logic signed [psc_pkg::SUM_W-1:0]     a_i,
  input  wire logic signed [psc_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [psc_pkg::PROD_W-1:0]         prod_o
);
  import psc_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

[sv/psc_ctrl.sv]
// Sequencer that steps the shared multiplier through the filter passes and tracks warm-up.
`default_nettype none
module psc_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire              restart_i,
  input  wire              twice_i,
  input  wire              out_free_i,
  output psc_pkg::psc_ctrl_t ctrl_o
);
  import psc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [WARM_W-1:0] warm_q, warm_d;
  logic [WARM_W-1:0] c_q, c_d;
  logic [WARM_W-1:0] c_start;
  logic [OP_W-1:0]   nxt_op;
  logic              has_next;

  // The count seen by this sample, after an optional restart.
  assign c_start = restart_i ? '0 : warm_q;

  always_comb begin
    warm_d = warm_q;
    c_d    = c_q;
    if (start_i) begin
      c_d = c_start;
      if (c_start >= WARM_W'(WARM_TWICE - 1)) begin
        warm_d = WARM_W'(WARM_TWICE);
      end else begin
        warm_d = c_start + WARM_W'(1);
      end
    end
  end

  // Which pass follows the current one; later passes only run once their history is valid.
  always_comb begin
    nxt_op   = OP_GAIN;
    has_next = 1'b0;
    unique case (op_q)
      OP_PRE_A: begin
        if (c_q >= WARM_W'(1)) begin
          has_next = 1'b1;
          nxt_op   = twice_i ? OP_PRE_B : OP_LOW_A;
        end
      end
      OP_PRE_B: begin
        if (c_q >= WARM_W'(2)) begin
          has_next = 1'b1;
          nxt_op   = OP_LOW_A;
        end
      end
      OP_LOW_A: begin
        if (twice_i) begin
          has_next = (c_q >= WARM_W'(LOW_B_START));
          nxt_op   = OP_LOW_B;
        end else begin
          has_next = (c_q >= WARM_W'(WARM_SINGLE));
          nxt_op   = OP_GAIN;
        end
      end
      OP_LOW_B: begin
        has_next = (c_q >= WARM_W'(WARM_TWICE));
        nxt_op   = OP_GAIN;
      end
      default: begin
        has_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    ctrl_o.busy     = (state_q != ST_IDLE);
    ctrl_o.op       = op_q;
    ctrl_o.mul_en   = 1'b0;
    ctrl_o.acc_en   = 1'b0;
    ctrl_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_MUL;
          op_d    = OP_PRE_A;
        end
      end
      ST_MUL: begin
        ctrl_o.mul_en = 1'b1;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        if (op_q == OP_GAIN) begin
          // Hold the finished beat until the output register has room.
          if (out_free_i) begin
            ctrl_o.out_load = 1'b1;
            state_d         = ST_IDLE;
          end
        end else begin
          ctrl_o.acc_en = 1'b1;
          if (has_next) begin
            op_d    = nxt_op;
            state_d = ST_MUL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_PRE_A;
      warm_q  <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      warm_q  <= warm_d;
      c_q     <= c_d;
    end
  end

  a_mul_then_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |=> (state_q == ST_ACC))
    else $error("multiply step not followed by accumulate step");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == ST_IDLE))
    else $error("sample accepted while sequencer busy");

  a_warm_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm_q <= WARM_W'(WARM_TWICE))
    else $error("warm-up count past its cap");

  a_gain_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && op_q == OP_GAIN) |->
      (twice_i ? (c_q >= WARM_W'(WARM_TWICE)) : (c_q >= WARM_W'(WARM_SINGLE))))
    else $error("output produced before history filled");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after output load");

endmodule
`default_nettype wire

[sv/pre_emphasis_shaping_chain.sv]
// Top level of the pre-emphasis shaping chain: registers, histories, datapath and output stage.
//
// Usage: samples enter on the input channel (in_valid_i / in_stall_o) with sample_in_i and
// restart_i; shaped samples leave on the output channel (out_valid_o / out_stall_i). A beat
// moves when valid is high and stall is low. Configuration is written through cfg_we_i,
// cfg_index_i and cfg_data_i while the block is idle.
// Each sample runs through up to five passes of one shared multiplier: pre-emphasis (once or
// twice), low-frequency (once or twice) and gain. Every pass has a multiply step and an
// accumulate step. in_stall_o stays high from acceptance until the sequencer is back in idle,
// so a new sample is only accepted once the last one is through its passes, and sooner during
// warm-up, when later passes are skipped. During warm-up (4 samples single, 8 twice) no beat
// appears.
// in_stall_o is high while a sample is being processed. A finished beat waits in the output
// register; the next sample is accepted meanwhile, and the block only waits at the end of its
// gain pass while that register is still full and stalled.
// Reset clears all histories and the warm-up count and loads the default registers;
// restart_i does the same for the histories and count before its sample is processed.
`default_nettype none
module pre_emphasis_shaping_chain (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  wire                                          in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic signed [psc_pkg::SAMPLE_W-1:0]     sample_in_i,
  input  wire                                          restart_i,
  output logic                                         out_valid_o,
  input  wire                                          out_stall_i,
  output logic signed [psc_pkg::SAMPLE_W-1:0]          sample_out_o,
  output logic                                         clipped_o,
  input  wire                                          cfg_we_i,
  input  wire logic [psc_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  wire logic [psc_pkg::GAIN_W-1:0]              cfg_data_i
);
  import psc_pkg::*;

  psc_ctrl_t ctrl;

  logic signed [COEFF_W-1:0]  hf_q, lf_q;
  logic [GAIN_W-1:0]          gain_q;
  logic                       twice_q;

  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [INT_W-1:0]    acc_q;
  logic signed [SAMPLE_W-1:0] pre_a_q;
  logic signed [INT_W-1:0]    pre_b_q;
  logic signed [INT_W-1:0]    low_a_q [3];
  logic signed [INT_W-1:0]    low_b_q [3];
  logic signed [SUM_W-1:0]    sum_a_q, sum_b_q;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_clip_q;

  logic                       in_accept;
  logic                       out_free;
  logic signed [SUM_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   coeff_sh;
  logic signed [ACC_W-1:0]    coeff_term;
  logic signed [INT_W-1:0]    cur;
  logic signed [ACC_W-1:0]    cur_w;
  logic signed [ACC_W-1:0]    stage_w;
  logic signed [INT_W-1:0]    stage_r;
  logic signed [SUM_W-1:0]    new_sum_a, new_sum_b;
  logic signed [PROD_W-1:0]   gain_sh;
  logic signed [SAMPLE_W-1:0] gain_r;
  logic                       gain_clip;
  logic                       is_pre;

  assign in_accept  = in_valid_i && !ctrl.busy;
  assign in_stall_o = ctrl.busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  psc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .restart_i  (restart_i),
    .twice_i    (twice_q),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = SUM_W'(acc_q);
    mul_b = MUL_B_W'(hf_q);
    case (ctrl.op)
      OP_PRE_A: begin
        mul_a = SUM_W'(pre_a_q);
        mul_b = MUL_B_W'(hf_q);
      end
      OP_PRE_B: begin
        mul_a = SUM_W'(pre_b_q);
        mul_b = MUL_B_W'(hf_q);
      end
      OP_LOW_A: begin
        mul_a = sum_a_q;
        mul_b = MUL_B_W'(lf_q);
      end
      OP_LOW_B: begin
        mul_a = sum_b_q;
        mul_b = MUL_B_W'(lf_q);
      end
      OP_GAIN: begin
        mul_a = SUM_W'(acc_q);
        mul_b = $signed({1'b0, gain_q});
      end
      default: begin
        mul_a = SUM_W'(acc_q);
        mul_b = MUL_B_W'(hf_q);
      end
    endcase
  end

  psc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Filter pass: current value minus or plus the shifted coefficient product, then clamp.
  assign is_pre     = (ctrl.op == OP_PRE_A) || (ctrl.op == OP_PRE_B);
  assign cur        = (ctrl.op == OP_PRE_A) ? INT_W'(x_q) : acc_q;
  assign cur_w      = ACC_W'(cur);
  assign coeff_sh   = prod >>> COEFF_FRAC;
  assign coeff_term = $signed(coeff_sh[ACC_W-1:0]);
  assign stage_w    = is_pre ? (cur_w - coeff_term) : (cur_w + coeff_term);
  assign stage_r    = sat_int(stage_w);

  // Running three-tap sums, ready for the next sample's multiply.
  assign new_sum_a = SUM_W'(acc_q) + SUM_W'(low_a_q[0]) + SUM_W'(low_a_q[1]);
  assign new_sum_b = SUM_W'(acc_q) + SUM_W'(low_b_q[0]) + SUM_W'(low_b_q[1]);

  // Gain scaling and symmetric output clamp.
  assign gain_sh = prod >>> GAIN_FRAC;
  always_comb begin
    gain_clip = 1'b0;
    gain_r    = gain_sh[SAMPLE_W-1:0];
    if (gain_sh > PROD_W'(SAMPLE_MAX)) begin
      gain_clip = 1'b1;
      gain_r    = SAMPLE_W'(SAMPLE_MAX);
    end else if (gain_sh < -PROD_W'(SAMPLE_MAX)) begin
      gain_clip = 1'b1;
      gain_r    = -SAMPLE_W'(SAMPLE_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hf_q    <= COEFF_W'(15565);
      lf_q    <= '0;
      gain_q  <= GAIN_W'(256);
      twice_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HF:    hf_q    <= $signed(cfg_data_i);
        CFG_LF:    lf_q    <= $signed(cfg_data_i);
        CFG_GAIN:  gain_q  <= cfg_data_i;
        CFG_TWICE: twice_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q <= sample_in_i;
    end
    if (ctrl.acc_en) begin
      acc_q <= stage_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_a_q <= '0;
      pre_b_q <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      for (int i = 0; i < 3; i++) begin
        low_a_q[i] <= '0;
        low_b_q[i] <= '0;
      end
    end else if (in_accept && restart_i) begin
      pre_a_q <= '0;
      pre_b_q <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      for (int i = 0; i < 3; i++) begin
        low_a_q[i] <= '0;
        low_b_q[i] <= '0;
      end
    end else if (ctrl.acc_en) begin
      case (ctrl.op)
        OP_PRE_A: pre_a_q <= x_q;
        OP_PRE_B: pre_b_q <= acc_q;
        OP_LOW_A: begin
          low_a_q[0] <= acc_q;
          low_a_q[1] <= low_a_q[0];
          low_a_q[2] <= low_a_q[1];
          sum_a_q    <= new_sum_a;
        end
        OP_LOW_B: begin
          low_b_q[0] <= acc_q;
          low_b_q[1] <= low_b_q[0];
          low_b_q[2] <= low_b_q[1];
          sum_b_q    <= new_sum_b;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_sample_q <= gain_r;
      out_clip_q   <= gain_clip;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign clipped_o    = out_clip_q;

endmodule
`default_nettype wire

[verif/tb_pre_emphasis_shaping_chain.sv]
// Self-checking testbench for the pre-emphasis shaping chain: directed and random samples vs. a local predictor.
module tb_pre_emphasis_shaping_chain;
  import psc_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 24;
  localparam int LONG_HOLD    = 240;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 130;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } shaped_beat_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic                       restart_i   = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       clipped_o;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = CFG_HF;
  logic [GAIN_W-1:0]          cfg_data_i  = '0;

  // Predictor copy of the registers and the filter histories.
  longint hf_cfg    = 15565;
  longint lf_cfg    = 0;
  longint gain_cfg  = 256;
  bit     twice_cfg = 1'b0;
  longint pre_hist [2];
  longint low_hist [2][3];
  int     warm_count;

  shaped_beat_t shaped_q[$];
  int           err_count   = 0;
  int           cycle_count = 0;
  bit           idle_on     = 1'b1;
  int           hold_trigger = 0;
  int           hold_served  = 0;
  int           hold_left    = 0;
  int           stall_burst  = 0;
  logic         stall_now;

  pre_emphasis_shaping_chain dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o),
    .clipped_o   (clipped_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint clamp_internal(input longint v);
    longint hi;
    hi = (longint'(1) << (INT_W - 1)) - 1;
    if (v > hi) begin
      return hi;
    end else if (v < -hi - 1) begin
      return -hi - 1;
    end
    return v;
  endfunction

  function automatic void clear_history();
    pre_hist   = '{0, 0};
    low_hist   = '{'{0, 0, 0}, '{0, 0, 0}};
    warm_count = 0;
  endfunction

  function automatic longint pre_pass(input longint cur, input int k);
    longint r;
    r = clamp_internal(cur - ((hf_cfg * pre_hist[k]) >>> COEFF_FRAC));
    pre_hist[k] = cur;
    return r;
  endfunction

  function automatic longint low_pass(input longint cur, input int k);
    longint sum;
    longint r;
    sum = low_hist[k][0] + low_hist[k][1] + low_hist[k][2];
    r = clamp_internal(cur + ((lf_cfg * sum) >>> COEFF_FRAC));
    low_hist[k][2] = low_hist[k][1];
    low_hist[k][1] = low_hist[k][0];
    low_hist[k][0] = cur;
    return r;
  endfunction

  // Runs one accepted sample through the filter chain and queues the beat it yields, if any.
  function automatic void shape_sample(input logic signed [SAMPLE_W-1:0] value,
                                       input logic restart);
    longint       s;
    longint       z;
    longint       p;
    int           c;
    bit           ok;
    shaped_beat_t beat;
    if (restart) clear_history();
    c  = warm_count;
    s  = pre_pass(longint'(value), 0);
    ok = (c >= 1);
    if (twice_cfg) begin
      if (ok) s = pre_pass(s, 1);
      ok = (c >= 2);
    end
    z = 0;
    if (ok) z = low_pass(s, 0);
    ok = (c >= (twice_cfg ? LOW_B_START : WARM_SINGLE));
    if (twice_cfg) begin
      if (ok) z = low_pass(z, 1);
      ok = (c >= WARM_TWICE);
    end
    warm_count = (c + 1 >= WARM_TWICE) ? WARM_TWICE : c + 1;
    if (ok) begin
      p = (z * gain_cfg) >>> GAIN_FRAC;
      beat.clipped = 1'b0;
      if (p > SAMPLE_MAX) begin
        p = SAMPLE_MAX;
        beat.clipped = 1'b1;
      end else if (p < -SAMPLE_MAX) begin
        p = -SAMPLE_MAX;
        beat.clipped = 1'b1;
      end
      beat.sample = p[SAMPLE_W-1:0];
      shaped_q.insert(shaped_q.size(), beat);
    end
  endfunction

  // Receiver: a long hold on request, otherwise random stall bursts.
  always @(posedge clk_i) begin
    if (hold_trigger != hold_served) begin
      hold_served = hold_trigger;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_now = 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst--;
      stall_now = 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_burst = $urandom_range(0, 9);
      stall_now   = 1'b1;
    end else begin
      stall_now = 1'b0;
    end
    out_stall_i <= stall_now;
  end

  always @(posedge clk_i) begin
    shaped_beat_t exp_beat;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (shaped_q.size() == 0) begin
        $error("unexpected beat: sample_out %0d clipped %0b", sample_out_o, clipped_o);
        err_count++;
      end else begin
        exp_beat = shaped_q.pop_front();
        if (sample_out_o !== exp_beat.sample) begin
          $error("sample_out expected %0d actual %0d", exp_beat.sample, sample_out_o);
          err_count++;
        end
        if (clipped_o !== exp_beat.clipped) begin
          $error("clipped expected %0b actual %0b", exp_beat.clipped, clipped_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic restart);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= value;
    restart_i   <= restart;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shape_sample(value, restart);
  endtask

  // Samples without a beat may still be in flight once the queue is empty.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (shaped_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [GAIN_W-1:0] hf, input logic [GAIN_W-1:0] lf,
                             input logic [GAIN_W-1:0] g, input bit tw);
    logic [GAIN_W-1:0] tw_data;
    wait_idle();
    tw_data    = GAIN_W'($urandom);
    tw_data[0] = tw;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_HF;
    cfg_data_i  <= hf;
    @(posedge clk_i);
    cfg_index_i <= CFG_LF;
    cfg_data_i  <= lf;
    @(posedge clk_i);
    cfg_index_i <= CFG_GAIN;
    cfg_data_i  <= g;
    @(posedge clk_i);
    cfg_index_i <= CFG_TWICE;
    cfg_data_i  <= tw_data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hf_cfg    = longint'($signed(hf));
    lf_cfg    = longint'($signed(lf));
    gain_cfg  = longint'(g);
    twice_cfg = tw;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0:       return SAMPLE_W'($urandom);
      1:       return SAMPLE_W'($urandom_range(0, 512) - 256);
      2:       return SAMPLE_W'($urandom_range(0, 8192) - 4096);
      default: return $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(32700, 32767))
                                           : SAMPLE_W'(-$urandom_range(32700, 32768));
    endcase
  endfunction

  task automatic test_default_config();
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'shffff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
  endtask

  task automatic test_coeff_extremes();
    load_config(16'h8000, 16'h7fff, 16'hffff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    load_config(16'h7fff, 16'h8000, 16'h0000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
  endtask

  task automatic test_twice_mode();
    load_config(16'd15565, 16'd4096, 16'd256, 1'b1);
    send_sample(16'sh1000, 1'b1);
    for (int i = 0; i < 9; i++) send_sample(rand_sample(), 1'b0);
  endtask

  // Mode drops back to single without a restart; pass-through coefficients expose the clamp.
  task automatic test_mode_change();
    load_config(16'h0000, 16'h0000, 16'd256, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
  endtask

  task automatic test_output_backpressure();
    load_config(16'd15565, 16'd2048, 16'd300, 1'b0);
    hold_trigger++;
    for (int i = 0; i < 40; i++) send_sample(rand_sample(), i == 0);
  endtask

  task automatic test_random_traffic();
    logic [GAIN_W-1:0] hf;
    logic [GAIN_W-1:0] lf;
    logic [GAIN_W-1:0] g;
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       hf = 16'h8000;
        1:       hf = 16'h7fff;
        2, 3:    hf = GAIN_W'($urandom);
        default: hf = GAIN_W'($urandom_range(0, 16384));
      endcase
      case ($urandom_range(0, 5))
        0:       lf = 16'h8000;
        1:       lf = 16'h7fff;
        2:       lf = GAIN_W'($urandom);
        default: lf = GAIN_W'($urandom_range(0, 4096) - 2048);
      endcase
      case ($urandom_range(0, 5))
        0:       g = 16'h0000;
        1:       g = 16'hffff;
        2:       g = GAIN_W'($urandom);
        default: g = GAIN_W'($urandom_range(64, 768));
      endcase
      load_config(hf, lf, g, 1'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(rand_sample(),
                    (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 59) == 0));
      end
    end
  endtask

  task automatic test_full_rate();
    load_config(16'd15565, 16'd1024, 16'd256, 1'($urandom_range(0, 1)));
    idle_on = 1'b0;
    for (int i = 0; i < 100; i++) send_sample(rand_sample(), i == 0);
  endtask

  initial begin
    clear_history();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_config();
    test_coeff_extremes();
    test_twice_mode();
    test_mode_change();
    test_output_backpressure();
    test_random_traffic();
    test_full_rate();
    wait_idle();
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
